// ===== rtl/scanline_run_extract_with_moment_macros.svh =====
// Assertion macros for the scan-line run extractor.
// Used by the top level only; relies on clk_i and rst_ni being in scope.
`ifndef SCANLINE_RUN_EXTRACT_WITH_MOMENT_MACROS_SVH
`define SCANLINE_RUN_EXTRACT_WITH_MOMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLREM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLREM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slrem_pkg.sv =====
// Shared constants, types and helper functions of the scan-line run extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package slrem_pkg;

  localparam int unsigned MAX_LINE_LENGTH = 1024;
  localparam int unsigned MAX_ORDER       = 4;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned LINE_W          = 10;
  localparam int unsigned ORD_W           = 3;
  localparam int unsigned Q_W             = 3;
  localparam int unsigned SUM_W           = 51;
  localparam int unsigned POW_W           = 51;
  localparam int unsigned MOM_W           = 58;
  localparam int unsigned FRAC_W          = 8;
  localparam int unsigned DIV_W           = 64;
  localparam int unsigned DIV_BITS        = 8;
  localparam int unsigned DIV_STEPS       = DIV_W / DIV_BITS;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam int unsigned FIFO_AW         = 2;

  typedef enum logic {
    KIND_RUN    = 1'b0,
    KIND_MOMENT = 1'b1
  } kind_e;

  typedef struct packed {
    logic              has_run;
    logic              has_mom;
    logic [LINE_W-1:0] line;
    logic [POS_W-1:0]  run_start;
    logic [POS_W-1:0]  run_end;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [LINE_W-1:0] line;
    logic [POS_W-1:0]  run_start;
    logic [POS_W-1:0]  run_end;
    logic [MOM_W-1:0]  moment;
    logic              last;
  } res_t;

  // Exponent q is the order plus one, with the order clamped to its maximum.
  function automatic logic [Q_W-1:0] exponent(input logic [ORD_W-1:0] order);
    logic [ORD_W-1:0] p;
    p = order;
    if (p > ORD_W'(MAX_ORDER)) begin
      p = ORD_W'(MAX_ORDER);
    end
    return Q_W'(p) + Q_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/slrem_front.sv =====
// Front part: accepts pixels, tracks runs, position and line index.
// Produces one command per pixel that causes results; uses slrem_pkg.
`default_nettype none

module slrem_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  output logic               pix_ready_o,
  input  logic               pix_black_i,
  input  logic               pix_eol_i,
  input  logic               pix_first_i,
  output logic               push_o,
  output slrem_pkg::cmd_t    cmd_o,
  input  logic               full_i
);
  import slrem_pkg::*;

  logic              in_run_q, in_run_d;
  logic [POS_W-1:0]  open_start_q, open_start_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic              accept;
  logic [LINE_W-1:0] line_cur;
  logic [POS_W-1:0]  start_cur;
  logic [POS_W-1:0]  end_raw;
  logic              close_run;

  assign pix_ready_o = !full_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign line_cur    = pix_first_i ? '0 : line_q;

  always_comb begin
    in_run_d     = in_run_q;
    open_start_d = open_start_q;
    pos_d        = pos_q;
    line_d       = line_q;
    close_run    = 1'b0;
    start_cur    = open_start_q;
    end_raw      = pos_q;
    if (pix_black_i) begin
      if (!in_run_q) begin
        start_cur = pos_q;
      end
      close_run = pix_eol_i;
    end else if (in_run_q) begin
      close_run = 1'b1;
      end_raw   = (pos_q == '0) ? '0 : pos_q - POS_W'(1);
    end
    if (accept) begin
      in_run_d     = pix_black_i && !pix_eol_i;
      open_start_d = start_cur;
      line_d       = line_cur;
      if (pix_eol_i) begin
        pos_d  = '0;
        line_d = line_cur + LINE_W'(1);
      end else if (pos_q != POS_W'(MAX_LINE_LENGTH - 1)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign push_o            = accept && (close_run || pix_eol_i);
  assign cmd_o.has_run     = close_run;
  assign cmd_o.has_mom     = pix_eol_i;
  assign cmd_o.line        = line_cur;
  assign cmd_o.run_start   = start_cur;
  assign cmd_o.run_end     = (end_raw < start_cur) ? start_cur : end_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q     <= 1'b0;
      open_start_q <= '0;
      pos_q        <= '0;
      line_q       <= '0;
    end else begin
      in_run_q     <= in_run_d;
      open_start_q <= open_start_d;
      pos_q        <= pos_d;
      line_q       <= line_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slrem_fifo.sv =====
// Short command queue between the front and the back part.
// Holds slrem_pkg::cmd_t entries; uses slrem_pkg.
`default_nettype none

module slrem_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slrem_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output slrem_pkg::cmd_t cmd_o
);
  import slrem_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   count_q, count_d;

  assign full_o  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (FIFO_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slrem_back.sv =====
// Back part: raises run bounds to the power q, accumulates the line sum,
// divides it by q and drives the output register. Uses slrem_pkg.
`default_nettype none

module slrem_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [slrem_pkg::ORD_W-1:0] cfg_data_i,
  input  logic                     empty_i,
  input  slrem_pkg::cmd_t          cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output slrem_pkg::res_t          res_o
);
  import slrem_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_POW   = 6'b000010,
    S_ACC   = 6'b000100,
    S_EMITR = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMITM = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [ORD_W-1:0]   order_q;
  logic [Q_W-1:0]     qexp;
  cmd_t               cmd_q, cmd_d;
  logic [POW_W-1:0]   pa_q, pa_d, pb_q, pb_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [DIV_W-1:0]   dq_q, dq_d;
  logic [Q_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;
  logic               out_free;
  logic [POS_W:0]     base_a;
  logic [POW_W+POS_W:0] prod_a, prod_b;
  logic [POW_W-1:0]   term;
  logic [SUM_W:0]     sum_ext;
  logic [DIV_W-1:0]   div_dv;
  logic [Q_W-1:0]     div_rv;
  logic [Q_W:0]       div_r4;
  logic [DIV_W-1:0]   dividend;

  assign qexp     = exponent(order_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign base_a   = {1'b0, cmd_q.run_end} + (POS_W+1)'(1);
  assign prod_a   = pa_q * base_a;
  assign prod_b   = pb_q * cmd_q.run_start;
  assign term     = pa_q - pb_q;
  assign sum_ext  = {1'b0, sum_q} + {1'b0, term};
  assign dividend = DIV_W'({sum_q, {FRAC_W{1'b0}}});

  always_comb begin
    div_dv = dq_q;
    div_rv = rem_q;
    div_r4 = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      div_r4 = {div_rv, div_dv[DIV_W-1]};
      div_dv = {div_dv[DIV_W-2:0], 1'b0};
      if (div_r4 >= {1'b0, qexp}) begin
        div_rv    = Q_W'(div_r4 - {1'b0, qexp});
        div_dv[0] = 1'b1;
      end else begin
        div_rv = div_r4[Q_W-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    sum_d       = sum_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.has_run) begin
            pa_d    = POW_W'(1);
            pb_d    = POW_W'(1);
            cnt_d   = CNT_W'(qexp);
            state_d = S_POW;
          end else begin
            dq_d    = dividend;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end
        end
      end
      S_POW: begin
        pa_d  = prod_a[POW_W-1:0];
        pb_d  = prod_b[POW_W-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        state_d = S_EMITR;
      end
      S_EMITR: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          res_d.kind      = KIND_RUN;
          res_d.line      = cmd_q.line;
          res_d.run_start = cmd_q.run_start;
          res_d.run_end   = cmd_q.run_end;
          res_d.moment    = '0;
          res_d.last      = !cmd_q.has_mom;
          if (cmd_q.has_mom) begin
            dq_d    = dividend;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        dq_d  = div_dv;
        rem_d = div_rv;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_EMITM;
        end
      end
      S_EMITM: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          res_d.kind      = KIND_MOMENT;
          res_d.line      = cmd_q.line;
          res_d.run_start = '0;
          res_d.run_end   = '0;
          res_d.moment    = (|dq_q[DIV_W-1:MOM_W]) ? '1 : dq_q[MOM_W-1:0];
          res_d.last      = 1'b1;
          sum_d           = '0;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        order_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scanline_run_extract_with_moment.sv =====
// Usage: the slave stream takes one pixel per transaction: tdata bit 0 is the
// black flag, tlast marks the last pixel of a line and tuser restarts the line
// index at zero. Every run of black pixels yields a run result; the last pixel
// of a line then yields the line's moment result, floor(S * 256 / q), where S
// sums (end+1)^q - start^q over the line's runs and q is the order plus one,
// with the order clamped to 4. The configuration channel writes the moment
// order; it is always ready and is to be written only while the block is idle.
// Throughput: a pixel is taken whenever the four-entry command queue has room,
// so pixels without results stream at one per cycle. The back unit handles one
// command at a time: for a run it raises both bounds in S_POW (one multiply per
// cycle for the powers), adds the term to the sum in S_ACC and offers the run
// result in S_EMITR; for a moment it divides in S_DIV (eight bits of the
// division per cycle) and offers the moment result in S_EMITM.
// Reset clears the order to zero, the line index, position, open run and sum.
// When the receiver stalls the result waits in the output register, the back
// unit stops, and the input stalls once the queue is full.
// Depends on slrem_pkg, slrem_front, slrem_fifo, slrem_back and the macros.
`default_nettype none

`include "scanline_run_extract_with_moment_macros.svh"

module scanline_run_extract_with_moment (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,     // moment_order
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel_black, zero fill
  input  logic        s_axis_tlast,   // end_of_line
  input  logic [0:0]  s_axis_tuser,   // first_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // line_index, run_start, run_end, moment
  output logic        m_axis_tlast,   // last
  output logic [0:0]  m_axis_tuser    // kind
);
  import slrem_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;
  res_t res;

  assign cfg_ready_o = 1'b1;

  slrem_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_black_i (s_axis_tdata[0]),
    .pix_eol_i   (s_axis_tlast),
    .pix_first_i (s_axis_tuser[0]),
    .push_o      (push),
    .cmd_o       (cmd_in),
    .full_i      (full)
  );

  slrem_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  slrem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.moment, res.run_end, res.run_start, res.line};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.kind;

  `SLREM_ASSERT_SAME(a_moment_is_last, m_axis_tvalid && (m_axis_tuser == KIND_MOMENT), m_axis_tlast, "moment result not marked last")
  `SLREM_ASSERT_SAME(a_run_bounds, m_axis_tvalid && (m_axis_tuser == KIND_RUN), m_axis_tdata[19:10] <= m_axis_tdata[29:20], "run end below run start")
  `SLREM_ASSERT_SAME(a_run_no_moment, m_axis_tvalid && (m_axis_tuser == KIND_RUN), m_axis_tdata[87:30] == '0, "run result carries a moment")
  `SLREM_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the scan-line run extractor with per-line moment.
// Drives pixel streams, predicts run and moment results and compares them in order.
// Depends on slrem_pkg and on the top level scanline_run_extract_with_moment.
`timescale 1ns / 100ps

module testbench;
  import slrem_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE      = 40;
  localparam logic [63:0] SUM_CAP     = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] MOM_CAP     = (64'd1 << MOM_W) - 64'd1;

  typedef struct packed {
    logic black;
    logic eol;
    logic first;
  } pixel_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i    = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic [0:0]  s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  scanline_run_extract_with_moment dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pixel_t pixel_q[$];
  res_t   runs_moments_q[$];
  int unsigned n_queued = 0;
  int unsigned n_sent   = 0;
  int unsigned errors   = 0;
  int unsigned cycles   = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // Own copy of the block's state and its order register.
  logic [2:0]       order_m  = 3'd0;
  logic             run_open = 1'b0;
  logic [POS_W-1:0] run_from = '0;
  logic [POS_W-1:0] col      = '0;
  logic [LINE_W-1:0] line_no = '0;
  logic [63:0]      acc      = '0;

  function automatic logic [63:0] raise(input logic [63:0] b, input int unsigned q);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned k = 0; k < q; k++) begin
      r = r * b;
    end
    return r;
  endfunction

  function automatic int unsigned q_now();
    return ((order_m > MAX_ORDER) ? MAX_ORDER : int'(order_m)) + 1;
  endfunction

  function automatic res_t make_res(input kind_e k, input logic [POS_W-1:0] rs,
                                    input logic [POS_W-1:0] re, input logic [63:0] m);
    res_t r;
    r.kind      = k;
    r.line      = line_no;
    r.run_start = rs;
    r.run_end   = re;
    r.moment    = m[MOM_W-1:0];
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic close_run(input logic [POS_W-1:0] end_pos, ref res_t made[$]);
    logic [POS_W-1:0] e;
    logic [63:0] s;
    e = (end_pos < run_from) ? run_from : end_pos;
    s = acc + raise(64'(e) + 64'd1, q_now()) - raise(64'(run_from), q_now());
    acc = (s > SUM_CAP) ? SUM_CAP : s;
    made.insert(made.size(), make_res(KIND_RUN, run_from, e, 64'd0));
    run_open = 1'b0;
  endtask

  task automatic trace_pixel(input pixel_t px);
    res_t made[$];
    logic [POS_W-1:0] here;
    logic [63:0] mom;
    here = col;
    if (px.first) begin
      line_no = '0;
    end
    if (px.black) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_from = here;
      end
    end else if (run_open) begin
      close_run((here == '0) ? '0 : here - 1'b1, made);
    end
    if (px.eol) begin
      if (run_open) begin
        close_run(here, made);
      end
      mom = (acc << FRAC_W) / 64'(q_now());
      if (mom > MOM_CAP) begin
        mom = MOM_CAP;
      end
      made.insert(made.size(), make_res(KIND_MOMENT, '0, '0, mom));
      acc = '0;
      col = '0;
      line_no = line_no + 1'b1;
    end else if (col != POS_W'(MAX_LINE_LENGTH - 1)) begin
      col = col + 1'b1;
    end
    if (made.size() > 0) begin
      made[made.size()-1].last = 1'b1;
    end
    foreach (made[i]) begin
      runs_moments_q.insert(runs_moments_q.size(), made[i]);
    end
  endtask

  // Pixel driver: predicts on every accepted transaction, then offers the next pixel.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t px;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        trace_pixel(pixel_t'({s_axis_tdata[0], s_axis_tlast, s_axis_tuser[0]}));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          px = pixel_q.pop_front();
          s_axis_tdata  <= {7'd0, px.black};
          s_axis_tlast  <= px.eol;
          s_axis_tuser  <= px.first;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = kind_e'(m_axis_tuser[0]);
        got.line      = m_axis_tdata[9:0];
        got.run_start = m_axis_tdata[19:10];
        got.run_end   = m_axis_tdata[29:20];
        got.moment    = m_axis_tdata[87:30];
        got.last      = m_axis_tlast;
        if (runs_moments_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind %0d line %0d run %0d..%0d moment %0d last %0d",
                   $time, got.kind, got.line, got.run_start, got.run_end, got.moment,
                   got.last);
        end else begin
          want = runs_moments_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch, expected kind %0d line %0d run %0d..%0d moment %0d last %0d",
                     $time, want.kind, want.line, want.run_start, want.run_end,
                     want.moment, want.last);
            $display("%0t:           actual kind %0d line %0d run %0d..%0d moment %0d last %0d",
                     $time, got.kind, got.line, got.run_start, got.run_end, got.moment,
                     got.last);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic put(input logic black, input logic eol, input logic first);
    pixel_q.insert(pixel_q.size(), pixel_t'({black, eol, first}));
    n_queued++;
  endtask

  task automatic drain();
    while (n_sent != n_queued || runs_moments_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_order(input logic [2:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_m = v;
  endtask

  task automatic random_lines(input int unsigned n);
    int unsigned done;
    int unsigned len;
    logic blk;
    done = 0;
    while (done < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      blk = 1'($urandom_range(1));
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(2) == 0) begin
          blk = !blk;
        end
        put(blk, i == len - 1,
            (i == 0) ? ($urandom_range(7) == 0) : ($urandom_range(39) == 0));
      end
      done += len;
    end
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short runs, run closed by line end, empty line and a one-pixel line.
    put(1'b1, 1'b0, 1'b1);
    put(1'b0, 1'b0, 1'b0);
    put(1'b1, 1'b0, 1'b0);
    put(1'b1, 1'b0, 1'b0);
    put(1'b1, 1'b1, 1'b0);
    put(1'b0, 1'b1, 1'b0);
    put(1'b1, 1'b1, 1'b0);
    // Line index restarted in the middle of a line, which is then left open.
    put(1'b0, 1'b0, 1'b0);
    put(1'b1, 1'b0, 1'b1);
    put(1'b0, 1'b0, 1'b0);
    put(1'b1, 1'b0, 1'b0);
    drain();
    // The order changes while a run is still open on the current line.
    write_order(3'd2);
    put(1'b0, 1'b0, 1'b0);
    put(1'b1, 1'b0, 1'b0);
    put(1'b1, 1'b1, 1'b0);
    drain();
    write_order(3'd7);
    put(1'b1, 1'b0, 1'b1);
    put(1'b1, 1'b0, 1'b0);
    put(1'b0, 1'b0, 1'b0);
    put(1'b1, 1'b1, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 80;
        end
        default: begin
          idle_pct  = 17;
          stall_pct = 17;
        end
      endcase
      write_order(3'($urandom_range(7)));
      random_lines(95);
      drain();
      random_lines(95);
      drain();
    end

    if (errors == 0 && runs_moments_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/slrem_pkg.sv
rtl/slrem_front.sv
rtl/slrem_fifo.sv
rtl/slrem_back.sv
rtl/scanline_run_extract_with_moment.sv
tb/sv/testbench.sv
